// File: src/bfdh_pkg.sv
`default_nettype none
// -----------------------------------------------------------------------------
// bfdh_pkg
// Shared types and constants of the double-hashing Bloom filter.
// -----------------------------------------------------------------------------
package bfdh_pkg;

  localparam int unsigned MAX_BITS_DEF   = 65536;
  localparam int unsigned MAX_PROBES_DEF = 32;

  localparam int unsigned HC_W = 6;
  localparam int unsigned BB_W = 17;

  localparam logic [HC_W-1:0] HASH_NUM_RST    = 6'd4;
  localparam logic [BB_W-1:0] BITMAP_BITS_RST = 17'd65536;

  localparam logic [1:0] CFG_HASH_NUM    = 2'd0;
  localparam logic [1:0] CFG_BITMAP_BITS = 2'd1;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  // remainder operand select
  localparam logic [1:0] SEL_WRAP = 2'd0;
  localparam logic [1:0] SEL_BASE = 2'd1;
  localparam logic [1:0] SEL_STEP = 2'd2;

  typedef struct packed {
    logic       accept;
    logic       clear_step;
    logic       rem_start;
    logic [1:0] start_sel;
    logic       rem_capture;
    logic [1:0] cap_sel;
    logic       probe_init;
    logic       probe_read;
    logic       probe_update;
    logic       result_load;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic rem_done;
    logic no_probes;
    logic last_probe;
    logic item_query;
    logic out_busy;
  } sts_t;

endpackage
`default_nettype wire

// File: src/bfdh_ram.sv
`default_nettype none
// -----------------------------------------------------------------------------
// bfdh_ram
// Single-port RAM with registered read.
// -----------------------------------------------------------------------------
module bfdh_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8192,
  parameter int unsigned AW    = 13
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

// File: src/bfdh_rem.sv
`default_nettype none
// -----------------------------------------------------------------------------
// bfdh_rem
// Restoring remainder unit: 65-bit dividend, one quotient bit per cycle.
// -----------------------------------------------------------------------------
module bfdh_rem #(
  parameter int unsigned SW = 17
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [64:0]   dvd,
  input  wire logic [SW-1:0] dvs,
  output logic               done,
  output logic [SW-1:0]      rem
);

  logic [64:0]   sh;
  logic [SW-1:0] r;
  logic [6:0]    cnt;
  logic          busy;
  logic [SW:0]   t;
  logic [SW:0]   d;
  logic [SW-1:0] r_next;

  assign t = {r, sh[64]};
  assign d = {1'b0, dvs};
  assign r_next = (t >= d) ? SW'(t - d) : SW'(t);
  assign rem = r;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 7'd1;
        if (cnt == 7'd64) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh <= dvd;
      r  <= '0;
    end else if (busy) begin
      sh <= {sh[63:0], 1'b0};
      r  <= r_next;
    end
  end

endmodule
`default_nettype wire

// File: src/bfdh_ctrl.sv
`default_nettype none
// -----------------------------------------------------------------------------
// bfdh_ctrl
// Sequencer: clearing pass, three remainders, then one read and one update
// per probe.
// -----------------------------------------------------------------------------
module bfdh_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  input  wire bfdh_pkg::sts_t sts,
  output bfdh_pkg::cmd_t     cmd
);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_MOD   = 6'b000100,
    ST_RD    = 6'b001000,
    ST_UPD   = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  state_t     state, state_next;
  logic [1:0] sel, sel_next, sel_inc;

  always_comb begin
    unique case (sel)
      bfdh_pkg::SEL_WRAP: sel_inc = bfdh_pkg::SEL_BASE;
      bfdh_pkg::SEL_BASE: sel_inc = bfdh_pkg::SEL_STEP;
      default:            sel_inc = bfdh_pkg::SEL_WRAP;
    endcase
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    sel_next   = sel;
    cmd.start_sel = sel_inc;
    cmd.cap_sel   = sel;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cmd.accept = 1'b1;
        if (s_tvalid) begin
          cmd.rem_start = 1'b1;
          cmd.start_sel = bfdh_pkg::SEL_WRAP;
          sel_next      = bfdh_pkg::SEL_WRAP;
          state_next    = ST_MOD;
        end
      end
      ST_MOD: begin
        if (sts.rem_done) begin
          cmd.rem_capture = 1'b1;
          if (sel != bfdh_pkg::SEL_STEP) begin
            cmd.rem_start = 1'b1;
            sel_next      = sel_inc;
          end else begin
            cmd.probe_init = 1'b1;
            state_next     = sts.no_probes ? ST_DONE : ST_RD;
          end
        end
      end
      ST_RD: begin
        cmd.probe_read = 1'b1;
        state_next     = ST_UPD;
      end
      ST_UPD: begin
        cmd.probe_update = 1'b1;
        state_next       = sts.last_probe ? ST_DONE : ST_RD;
      end
      ST_DONE: begin
        if (!sts.item_query) begin
          state_next = ST_IDLE;
        end else if (!sts.out_busy) begin
          cmd.result_load = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      sel   <= bfdh_pkg::SEL_WRAP;
    end else begin
      state <= state_next;
      sel   <= sel_next;
    end
  end

endmodule
`default_nettype wire

// File: src/bfdh_dp.sv
`default_nettype none
// -----------------------------------------------------------------------------
// bfdh_dp
// Datapath: config registers, item registers, probe position walk, bit store
// and result register.
// -----------------------------------------------------------------------------
module bfdh_dp #(
  parameter int unsigned MAX_BITS   = bfdh_pkg::MAX_BITS_DEF,
  parameter int unsigned MAX_PROBES = bfdh_pkg::MAX_PROBES_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire bfdh_pkg::cmd_t  cmd,
  output bfdh_pkg::sts_t       sts,
  input  wire logic [127:0]    s_tdata,
  input  wire logic [0:0]      s_tuser,
  input  wire logic            cfg_valid,
  input  wire logic [1:0]      cfg_index,
  input  wire logic [16:0]     cfg_data,
  output logic                 m_tvalid,
  input  wire logic            m_tready,
  output logic [7:0]           m_tdata
);

  localparam int unsigned SW    = $clog2(MAX_BITS + 1);
  localparam int unsigned DEPTH = (MAX_BITS + 7) / 8;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned PCW   = $clog2(MAX_PROBES + 1);

  logic [bfdh_pkg::HC_W-1:0] hash_num;
  logic [bfdh_pkg::BB_W-1:0] bitmap_bits;
  logic [bfdh_pkg::BB_W:0]   rounded;
  logic [SW-1:0]             size;
  logic [PCW-1:0]            probes;

  logic                op;
  logic [63:0]         base, step, acc;
  logic [SW-1:0]       wrap_rem, base_rem, step_rem, pos;
  logic [PCW-1:0]      left;
  logic                all_set;
  logic [AW-1:0]       clr;

  logic [64:0]         dvd;
  logic                rem_done;
  logic [SW-1:0]       rem;

  logic [64:0]         acc_sum;
  logic [SW:0]         t0;
  logic [SW-1:0]       t1, pos_next;

  logic                ram_we;
  logic [AW-1:0]       ram_addr;
  logic [7:0]          ram_wdata, ram_rdata;

  always_comb begin
    rounded = ({1'b0, bitmap_bits} + 18'd7) & ~18'd7;
    if (rounded == '0) begin
      size = SW'(8);
    end else if (32'(rounded) > 32'(MAX_BITS)) begin
      size = SW'(MAX_BITS);
    end else begin
      size = SW'(rounded);
    end
    if (32'(hash_num) > 32'(MAX_PROBES)) begin
      probes = PCW'(MAX_PROBES);
    end else begin
      probes = PCW'(hash_num);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_num    <= bfdh_pkg::HASH_NUM_RST;
      bitmap_bits <= bfdh_pkg::BITMAP_BITS_RST;
    end else if (cfg_valid) begin
      if (cfg_index == bfdh_pkg::CFG_HASH_NUM) begin
        hash_num <= cfg_data[bfdh_pkg::HC_W-1:0];
      end else if (cfg_index == bfdh_pkg::CFG_BITMAP_BITS) begin
        bitmap_bits <= cfg_data;
      end
    end
  end

  always_comb begin
    unique case (cmd.start_sel)
      bfdh_pkg::SEL_WRAP: dvd = {1'b1, 64'd0};
      bfdh_pkg::SEL_BASE: dvd = {1'b0, base};
      default:            dvd = {1'b0, step};
    endcase
  end

  bfdh_rem #(.SW(SW)) u_rem (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.rem_start),
    .dvd   (dvd),
    .dvs   (size),
    .done  (rem_done),
    .rem   (rem)
  );

  // next position: (pos + step_rem) mod size, minus 2^64 mod size on wrap
  always_comb begin
    acc_sum = {1'b0, acc} + {1'b0, step};
    t0      = {1'b0, pos} + {1'b0, step_rem};
    t1      = (t0 >= {1'b0, size}) ? SW'(t0 - {1'b0, size}) : SW'(t0);
    if (!acc_sum[64]) begin
      pos_next = t1;
    end else if (t1 >= wrap_rem) begin
      pos_next = t1 - wrap_rem;
    end else begin
      pos_next = SW'({1'b0, t1} + {1'b0, size} - {1'b0, wrap_rem});
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op   <= s_tuser[0];
      base <= s_tdata[63:0];
      step <= s_tdata[127:64];
    end
    if (cmd.rem_capture) begin
      unique case (cmd.cap_sel)
        bfdh_pkg::SEL_WRAP: wrap_rem <= rem;
        bfdh_pkg::SEL_BASE: base_rem <= rem;
        default:            step_rem <= rem;
      endcase
    end
    if (cmd.probe_init) begin
      acc     <= base;
      pos     <= base_rem;
      left    <= probes;
      all_set <= 1'b1;
    end else if (cmd.probe_update) begin
      acc     <= acc_sum[63:0];
      pos     <= pos_next;
      left    <= left - PCW'(1);
      all_set <= all_set & ram_rdata[pos[2:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr <= '0;
    end else if (cmd.clear_step) begin
      clr <= clr + AW'(1);
    end
  end

  assign ram_addr  = cmd.clear_step ? clr : pos[3 +: AW];
  assign ram_we    = cmd.clear_step || (cmd.probe_update && (op == bfdh_pkg::OP_INSERT));
  assign ram_wdata = cmd.clear_step ? 8'd0 : (ram_rdata | (8'd1 << pos[2:0]));

  bfdh_ram #(.WIDTH(8), .DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.result_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      m_tdata <= {7'd0, all_set};
    end
  end

  assign sts.clear_last = (clr == AW'(DEPTH - 1));
  assign sts.rem_done   = rem_done;
  assign sts.no_probes  = (probes == '0);
  assign sts.last_probe = (left == PCW'(1));
  assign sts.item_query = (op == bfdh_pkg::OP_QUERY);
  assign sts.out_busy   = m_tvalid && !m_tready;

endmodule
`default_nettype wire

// File: src/bloom_filter_double_hash.sv
`default_nettype none
// -----------------------------------------------------------------------------
// bloom_filter_double_hash
// Bloom filter with double hashing over a cleared bit store.
// -----------------------------------------------------------------------------
//  channel  signals                    carries
//  s        s_tvalid/s_tready          request: tuser operation, tdata hash halves
//  m        m_tvalid/m_tready          query answer maybe_present
//  cfg      cfg_valid/cfg_ready        register index and write data
//
//  A request runs three 65-step remainders (2^64, base, step mod size),
//  then a read and an update for each of P probes, P = effective probe count.
//  After reset a clearing pass over all ceil(MAX_BITS/8) store bytes runs
//  before s_tready rises.
//  A query answer waits in the output register; the block stalls only when
//  a new answer is ready while the previous one is still not taken.
// -----------------------------------------------------------------------------
module bloom_filter_double_hash #(
  parameter int unsigned MAX_BITS   = bfdh_pkg::MAX_BITS_DEF,
  parameter int unsigned MAX_PROBES = bfdh_pkg::MAX_PROBES_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [127:0] s_tdata,   // hash_base[63:0], hash_step[127:64]
  input  wire logic [0:0]   s_tuser,   // operation[0]
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [7:0]        m_tdata,   // maybe_present[0], zero fill
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [16:0]  cfg_data
);

  bfdh_pkg::cmd_t cmd;
  bfdh_pkg::sts_t sts;

  assign s_tready  = cmd.accept;
  assign cfg_ready = 1'b1;

  bfdh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .sts      (sts),
    .cmd      (cmd)
  );

  bfdh_dp #(.MAX_BITS(MAX_BITS), .MAX_PROBES(MAX_PROBES)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

`ifndef ASSERT_OFF
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.clear_step |-> !s_tready) else $error("request accepted during clear");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready) else $error("request overlap");

  a_reset_no_result: assert property (@(posedge clk)
    rst |=> !m_tvalid) else $error("result after reset");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(cmd.result_load)) else $error("unexpected result");
`endif

endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
// -----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the double-hashing Bloom filter. Insert and query
// requests are driven on the s channel, with registers written between
// phases. A scoreboard keeps its own bit store and checks each query answer
// in order.
// -----------------------------------------------------------------------------
module tb_top;
  import bfdh_pkg::*;

  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int         STORE_BITS = 65536;
  localparam int         PROBE_CAP  = 32;
  localparam int         SETTLE     = 400;
  localparam int         IDLE_LIMIT = 20000;
  localparam int         LONG_HOLD  = 3000;

  class bloom_scoreboard;
    bit          filter[STORE_BITS];
    logic [5:0]  hash_num;
    logic [16:0] bitmap_bits;
    bit          answers[$];
    int          errors;

    function void clear();
      foreach (filter[i]) filter[i] = 0;
      hash_num    = HASH_NUM_RST;
      bitmap_bits = BITMAP_BITS_RST;
      answers.delete();
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [16:0] val);
      if (idx == CFG_HASH_NUM) hash_num = val[5:0];
      else if (idx == CFG_BITMAP_BITS) bitmap_bits = val;
    endfunction

    function void note_request(logic op, logic [63:0] base, logic [63:0] step);
      logic [17:0] size;
      int          probes;
      logic [63:0] pos;
      int          bit_idx;
      bit          all_set;
      size = ({1'b0, bitmap_bits} + 18'd7) & ~18'd7;
      if (size < 8) size = 8;
      if (size > STORE_BITS) size = STORE_BITS;
      probes  = hash_num > PROBE_CAP ? PROBE_CAP : hash_num;
      all_set = 1;
      for (int i = 0; i < probes; i++) begin
        pos     = base + 64'(i) * step;
        bit_idx = int'(pos % 64'(size));
        if (op == OP_INSERT) filter[bit_idx] = 1;
        else if (!filter[bit_idx]) all_set = 0;
      end
      if (op == OP_QUERY) answers.push_back(all_set);
    endfunction

    function void check_answer(logic [7:0] data);
      bit want;
      if (answers.size() == 0) begin
        $error("maybe_present: answer with no query pending, got %0d", data[0]);
        errors++;
        return;
      end
      want = answers.pop_front();
      if (data[0] !== want) begin
        $error("maybe_present: expected %0d, got %0d", want, data[0]);
        errors++;
      end
      if (data[7:1] !== 7'd0) begin
        $error("m_tdata fill: expected 0, got %0h", data[7:1]);
        errors++;
      end
    endfunction
  endclass

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [127:0] s_tdata = '0;
  logic [0:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [7:0]   m_tdata;
  logic         cfg_valid = 0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = '0;
  logic [16:0]  cfg_data = '0;

  bloom_scoreboard sb = new();
  logic [127:0]    key_pool[$];
  int              idle_cycles = 0;
  int              hold_cnt = 0;
  bit              hold_req = 0;
  bit              no_idle = 0;

  bloom_filter_double_hash u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // answer side: random stalls, one long hold on request
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_answer(m_tdata);
    if (hold_req) begin
      hold_req = 0;
      hold_cnt = LONG_HOLD;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      m_tready <= 0;
    end else if (!no_idle && $urandom_range(0, 3) == 0) begin
      hold_cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
      m_tready <= 0;
    end else begin
      m_tready <= 1;
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic cfg_write(logic [1:0] idx, logic [16:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic send_request(logic op, logic [63:0] base, logic [63:0] step);
    int gap;
    gap = 0;
    if (!no_idle && $urandom_range(0, 2) == 0)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 100) : $urandom_range(1, 4);
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser  <= op;
    s_tdata  <= {step, base};
    do @(posedge clk); while (!s_tready);
    sb.note_request(op, base, step);
  endtask

  task automatic wait_idle();
    s_tvalid <= 0;
    while (sb.answers.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic random_phase(int count);
    logic [63:0]  base, step;
    logic [127:0] k;
    logic         op;
    for (int n = 0; n < count; n++) begin
      op = $urandom_range(0, 1) ? OP_QUERY : OP_INSERT;
      base = {$urandom, $urandom};
      step = {$urandom, $urandom};
      if ($urandom_range(0, 7) == 0) step = $urandom_range(0, 3);
      if (op == OP_QUERY && key_pool.size() > 0 && $urandom_range(0, 9) < 6) begin
        k = key_pool[$urandom_range(0, key_pool.size() - 1)];
        base = k[63:0];
        step = k[127:64];
      end
      if (op == OP_INSERT) begin
        key_pool.push_back({step, base});
        if (key_pool.size() > 64) void'(key_pool.pop_front());
      end
      send_request(op, base, step);
    end
  endtask

  task automatic run_setting(logic [16:0] hc, logic [16:0] bits, int count);
    wait_idle();
    cfg_write(CFG_HASH_NUM, hc);
    cfg_write(CFG_BITMAP_BITS, bits);
    random_phase(count);
  endtask

  initial begin
    sb.clear();
    repeat (9) @(posedge clk);
    rst <= 0;

    // directed: default setting, extremes of both hash halves
    send_request(OP_QUERY, 64'd0, 64'd0);
    send_request(OP_INSERT, 64'd0, 64'd0);
    send_request(OP_QUERY, 64'd0, 64'd0);
    send_request(OP_INSERT, '1, '1);
    send_request(OP_QUERY, '1, '1);
    send_request(OP_QUERY, '1, 64'd1);
    send_request(OP_INSERT, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF);
    send_request(OP_QUERY, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF);
    send_request(OP_QUERY, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    wait_idle();
    // no probes
    cfg_write(CFG_HASH_NUM, 17'd0);
    send_request(OP_INSERT, 64'h1234, 64'h5678);
    send_request(OP_QUERY, 64'hDEAD_BEEF, 64'h1);
    wait_idle();
    // saturated probe count, unknown index ignored, oversize store
    cfg_write(CFG_HASH_NUM, 17'h1FFFF);
    cfg_write(CFG_UNUSED, 17'd5);
    cfg_write(CFG_BITMAP_BITS, 17'h1FFFF);
    send_request(OP_INSERT, '1, 64'd3);
    send_request(OP_QUERY, '1, 64'd3);
    wait_idle();
    // size zero and size not a multiple of eight
    cfg_write(CFG_BITMAP_BITS, 17'd0);
    send_request(OP_QUERY, 64'd9, 64'd1);
    send_request(OP_INSERT, 64'd9, 64'd1);
    send_request(OP_QUERY, 64'd1, 64'd0);
    wait_idle();
    cfg_write(CFG_BITMAP_BITS, 17'd13);
    send_request(OP_QUERY, 64'd15, 64'd1);
    send_request(OP_INSERT, 64'd100, 64'd7);
    send_request(OP_QUERY, 64'd15, 64'd1);

    run_setting(17'd4, 17'd65536, 120);
    run_setting(17'd32, 17'd8, 100);
    run_setting(17'd1, 17'd64, 130);
    // long receiver hold while requests keep coming
    wait_idle();
    hold_req = 1;
    random_phase(60);
    run_setting(17'd63, 17'd100, 100);
    no_idle = 1;
    run_setting(17'd3, 17'd512, 120);
    no_idle = 0;
    run_setting(17'd0, 17'd131071, 40);
    run_setting(17'd7, 17'd1001, 140);
    run_setting(17'd2, 17'd256, 130);
    run_setting(17'($urandom_range(0, 63)), 17'($urandom_range(0, 2047)), 90);

    s_tvalid <= 0;
    while (sb.answers.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (sb.errors == 0 && sb.answers.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
